@@ design/pcomp_pkg.sv @@
// Shared types, constants and helpers for the pressure sensor compensation pipeline.
package pcomp_pkg;

    localparam int unsigned COEFF_W     = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned NUM_STAGES  = 9;

    // Scaling shifts (divisions by powers of two)
    localparam int unsigned TEMP_SHIFT     = 23;
    localparam int unsigned OFF_SHIFT      = 16;
    localparam int unsigned OFF_DT_SHIFT   = 7;
    localparam int unsigned SENS_SHIFT     = 15;
    localparam int unsigned SENS_DT_SHIFT  = 8;
    localparam int unsigned TI_COLD_SHIFT  = 33;
    localparam int unsigned TI_WARM_SHIFT  = 36;
    localparam int unsigned PRESS_SHIFT    = 21;
    localparam int unsigned FINAL_SHIFT    = 13;
    localparam int unsigned SENS_SPLIT     = 19;

    localparam logic signed [63:0] TEMP_BASE = 64'sd2000;
    localparam logic signed [63:0] COLD_EDGE = -64'sd1500;
    localparam logic signed [63:0] TEMP_MIN  = -64'sd4000;
    localparam logic signed [63:0] TEMP_MAX  = 64'sd8500;
    localparam logic signed [63:0] PRESS_MIN = 64'sd0;
    localparam logic signed [63:0] PRESS_MAX = 64'sd300000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [COEFF_W-1:0] sens_coeff;
        logic [COEFF_W-1:0] offset_coeff;
        logic [COEFF_W-1:0] sens_temp_coeff;
        logic [COEFF_W-1:0] offset_temp_coeff;
        logic [COEFF_W-1:0] ref_temp_coeff;
        logic [COEFF_W-1:0] temp_slope_coeff;
    } coeff_t;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } in_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [18:0]        pressure_deci_mbar;
        logic               out_of_range;
    } out_t;

    // First-order results
    typedef struct packed {
        logic signed [18:0] temp0;
        logic signed [34:0] off;
        logic signed [33:0] sens;
        logic [16:0]        ti_cold;
        logic [12:0]        ti_warm;
        logic [23:0]        raw_pressure;
    } front_t;

    // After second-order correction
    typedef struct packed {
        logic signed [18:0] temp;
        logic signed [39:0] off2;
        logic signed [38:0] sens2;
        logic [23:0]        raw_pressure;
    } second_t;

    // Arithmetic shift right that rounds toward zero
    function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] value,
                                                       input int unsigned shift);
        logic signed [63:0] bias;
        bias = value[63] ? ((64'sd1 <<< shift) - 64'sd1) : 64'sd0;
        return (value + bias) >>> shift;
    endfunction

endpackage

@@ design/pressure_sensor_compensation.sv @@
// An input transfer loads the first stage and the item then moves stage by stage to the last;
// m_valid is the valid of the last stage. Nine-stage pipeline, at most one multiplier level per stage.
// Throughput: one reading pair per cycle while the output is not held back.
// Each stage advances when empty or when the next one advances, so bubbles close up
// and a held result does not stop upstream stages that still have room.
// Reset: aresetn, synchronous, active low; clears the coefficients and all stage valids.
module pressure_sensor_compensation
    import pcomp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]     cfg_wdata
);

    coeff_t                coeff_reg, coeff_next;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_en;
    front_t                front;
    second_t               second;

    always_comb begin
        coeff_next = coeff_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_SENS:        coeff_next.sens_coeff        = cfg_wdata;
                REG_OFFSET:      coeff_next.offset_coeff      = cfg_wdata;
                REG_SENS_TEMP:   coeff_next.sens_temp_coeff   = cfg_wdata;
                REG_OFFSET_TEMP: coeff_next.offset_temp_coeff = cfg_wdata;
                REG_REF_TEMP:    coeff_next.ref_temp_coeff    = cfg_wdata;
                REG_TEMP_SLOPE:  coeff_next.temp_slope_coeff  = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage enables ripple back from the output
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end else begin
            valid_next[0] = valid_reg[0];
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
            valid_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
            valid_reg <= valid_next;
        end
    end

    pcomp_front u_front (
        .aclk     (aclk),
        .stage_en (stage_en[2:0]),
        .coeff    (coeff_reg),
        .s_data   (s_data),
        .front    (front)
    );

    pcomp_second u_second (
        .aclk     (aclk),
        .stage_en (stage_en[4:3]),
        .front    (front),
        .second   (second)
    );

    pcomp_press u_press (
        .aclk     (aclk),
        .stage_en (stage_en[8:5]),
        .second   (second),
        .result   (m_data)
    );

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

`ifndef ASSERT_OFF
    // An accepted transfer always lands in the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    // A stalled middle stage keeps its item
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NUM_STAGES-2] && !stage_en[NUM_STAGES-2] |=> valid_reg[NUM_STAGES-2])
        else $error("stalled stage lost its item");

    // With no result waiting the whole pipeline can move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // Results are always clipped to range
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.temperature_centi >= TEMP_MIN)
                 && (m_data.temperature_centi <= TEMP_MAX)
                 && (m_data.pressure_deci_mbar <= PRESS_MAX))
        else $error("result outside clipping range");
`endif

endmodule

@@ design/pcomp_front.sv @@
// First-order stages: dT, the four products, first-order temperature, offset and sensitivity.
module pcomp_front
    import pcomp_pkg::*;
(
    input  logic       aclk,
    input  logic [2:0] stage_en,
    input  coeff_t     coeff,
    input  in_t        s_data,
    output front_t     front
);

    logic signed [24:0] dt_reg, dt_next;
    logic [23:0]        d1_s0_reg;

    logic signed [41:0] pt_reg, pt_next;
    logic signed [41:0] po_reg, po_next;
    logic signed [41:0] ps_reg, ps_next;
    logic [48:0]        dtsq_reg, dtsq_next;
    logic signed [49:0] dtsq_full;
    logic [23:0]        d1_s1_reg;

    logic [49:0]        dtsq3;
    front_t             front_reg, front_next;

    always_comb begin
        dt_next = $signed({1'b0, s_data.raw_temperature})
                - $signed({1'b0, coeff.ref_temp_coeff, 8'd0});
    end

    always_comb begin
        pt_next   = dt_reg * $signed({1'b0, coeff.temp_slope_coeff});
        po_next   = dt_reg * $signed({1'b0, coeff.offset_temp_coeff});
        ps_next   = dt_reg * $signed({1'b0, coeff.sens_temp_coeff});
        dtsq_full = dt_reg * dt_reg;
        dtsq_next = dtsq_full[48:0];
    end

    always_comb begin
        dtsq3 = {1'b0, dtsq_reg} + {dtsq_reg, 1'b0};
        front_next.temp0 = 19'(TEMP_BASE + trunc_shift(64'(pt_reg), TEMP_SHIFT));
        front_next.off   = 35'((64'(coeff.offset_coeff) << OFF_SHIFT)
                         + trunc_shift(64'(po_reg), OFF_DT_SHIFT));
        front_next.sens  = 34'((64'(coeff.sens_coeff) << SENS_SHIFT)
                         + trunc_shift(64'(ps_reg), SENS_DT_SHIFT));
        front_next.ti_cold      = 17'(dtsq3 >> TI_COLD_SHIFT);
        front_next.ti_warm      = 13'(dtsq_reg >> TI_WARM_SHIFT);
        front_next.raw_pressure = d1_s1_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dt_reg    <= dt_next;
            d1_s0_reg <= s_data.raw_pressure;
        end
        if (stage_en[1]) begin
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
            dtsq_reg  <= dtsq_next;
            d1_s1_reg <= d1_s0_reg;
        end
        if (stage_en[2]) begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

@@ design/pcomp_second.sv @@
// Second-order stages: band selection, squared deviations, corrected offset and sensitivity.
module pcomp_second
    import pcomp_pkg::*;
(
    input  logic       aclk,
    input  logic [1:0] stage_en,
    input  front_t     front,
    output second_t    second
);

    logic signed [19:0] dev, cc;
    logic signed [39:0] devsq_full, ccsq_full;
    logic [34:0]        devsq_reg, devsq_next;
    logic [34:0]        ccsq_reg, ccsq_next;
    logic               cold_reg, cold_next;
    logic               very_cold_reg, very_cold_next;
    logic signed [18:0] t_reg, t_next;
    logic signed [34:0] off_reg;
    logic signed [33:0] sens_reg;
    logic [23:0]        d1_reg;

    logic [36:0]        devsq3;
    logic [37:0]        devsq5;
    logic [37:0]        ccsq7;
    logic [36:0]        ccsq4;
    logic [37:0]        offi;
    logic [36:0]        sensi;
    second_t            second_reg, second_next;

    always_comb begin
        dev            = 20'(front.temp0) - 20'(TEMP_BASE);
        cc             = 20'(front.temp0) - 20'(COLD_EDGE);
        devsq_full     = dev * dev;
        ccsq_full      = cc * cc;
        devsq_next     = devsq_full[34:0];
        ccsq_next      = ccsq_full[34:0];
        cold_next      = front.temp0 < TEMP_BASE;
        very_cold_next = front.temp0 < COLD_EDGE;
        t_next = front.temp0 - (cold_next ? $signed({2'b00, front.ti_cold})
                                          : $signed({6'd0, front.ti_warm}));
    end

    always_comb begin
        devsq3 = {2'b00, devsq_reg} + {1'b0, devsq_reg, 1'b0};
        devsq5 = {3'd0, devsq_reg} + {1'b0, devsq_reg, 2'b00};
        ccsq7  = {ccsq_reg, 3'd0} - {3'd0, ccsq_reg};
        ccsq4  = {ccsq_reg, 2'b00};
        if (cold_reg) begin
            offi  = 38'(devsq3 >> 1) + (very_cold_reg ? ccsq7 : 38'd0);
            sensi = 37'(devsq5 >> 3) + (very_cold_reg ? ccsq4 : 37'd0);
        end else begin
            offi  = 38'(devsq_reg >> 4);
            sensi = '0;
        end
        second_next.temp         = t_reg;
        second_next.off2         = 40'(off_reg) - 40'(offi);
        second_next.sens2        = 39'(sens_reg) - 39'(sensi);
        second_next.raw_pressure = d1_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            devsq_reg     <= devsq_next;
            ccsq_reg      <= ccsq_next;
            cold_reg      <= cold_next;
            very_cold_reg <= very_cold_next;
            t_reg         <= t_next;
            off_reg       <= front.off;
            sens_reg      <= front.sens;
            d1_reg        <= front.raw_pressure;
        end
        if (stage_en[1]) begin
            second_reg <= second_next;
        end
    end

    assign second = second_reg;

endmodule

@@ design/pcomp_press.sv @@
// Pressure stages: split D1 x SENS product, scaling, offset removal and output clipping.
module pcomp_press
    import pcomp_pkg::*;
(
    input  logic       aclk,
    input  logic [3:0] stage_en,
    input  second_t    second,
    output out_t       result
);

    logic signed [24:0] d1s;
    logic signed [19:0] sens_hi;
    logic signed [44:0] phi_reg, phi_next;
    logic [42:0]        plo_reg, plo_next;
    logic signed [39:0] off2_a_reg, off2_b_reg;
    logic signed [14:0] tclip_a_reg, tclip_b_reg, tclip_c_reg, tclip_next;
    logic               tflag_a_reg, tflag_b_reg, tflag_c_reg, tflag_next;

    logic signed [63:0] prod_reg, prod_next;
    logic signed [43:0] x_reg, x_next;
    logic signed [63:0] p;
    out_t               out_reg, out_next;

    // Stage: partial products over the low and high halves of SENS, temperature clip
    always_comb begin
        d1s      = $signed({1'b0, second.raw_pressure});
        sens_hi  = second.sens2[38:SENS_SPLIT];
        phi_next = d1s * sens_hi;
        plo_next = second.raw_pressure * second.sens2[SENS_SPLIT-1:0];
        if (second.temp < TEMP_MIN) begin
            tclip_next = 15'(TEMP_MIN);
            tflag_next = 1'b1;
        end else if (second.temp > TEMP_MAX) begin
            tclip_next = 15'(TEMP_MAX);
            tflag_next = 1'b1;
        end else begin
            tclip_next = 15'(second.temp);
            tflag_next = 1'b0;
        end
    end

    always_comb begin
        prod_next = (64'(phi_reg) <<< SENS_SPLIT) + 64'(plo_reg);
    end

    always_comb begin
        x_next = 44'(trunc_shift(prod_reg, PRESS_SHIFT) - 64'(off2_b_reg));
    end

    always_comb begin
        p = trunc_shift(64'(x_reg), FINAL_SHIFT);
        out_next.temperature_centi = tclip_c_reg;
        if (p < PRESS_MIN) begin
            out_next.pressure_deci_mbar = 19'(PRESS_MIN);
            out_next.out_of_range       = 1'b1;
        end else if (p > PRESS_MAX) begin
            out_next.pressure_deci_mbar = 19'(PRESS_MAX);
            out_next.out_of_range       = 1'b1;
        end else begin
            out_next.pressure_deci_mbar = 19'(p);
            out_next.out_of_range       = tflag_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            phi_reg     <= phi_next;
            plo_reg     <= plo_next;
            off2_a_reg  <= second.off2;
            tclip_a_reg <= tclip_next;
            tflag_a_reg <= tflag_next;
        end
        if (stage_en[1]) begin
            prod_reg    <= prod_next;
            off2_b_reg  <= off2_a_reg;
            tclip_b_reg <= tclip_a_reg;
            tflag_b_reg <= tflag_a_reg;
        end
        if (stage_en[2]) begin
            x_reg       <= x_next;
            tclip_c_reg <= tclip_b_reg;
            tflag_c_reg <= tflag_b_reg;
        end
        if (stage_en[3]) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule
